// ===== design/xbt_pkg.sv =====
// Shared types, character constants and character-class helpers for the
// XML byte tokenizer. No dependencies.
package xbt_pkg;

  localparam int BYTE_W = 8;
  localparam int EV_W   = 4;

  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;  // '!'
  localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;  // '='
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

  typedef enum logic [EV_W-1:0] {
    EV_ELEM_CHAR  = 4'd0,
    EV_ELEM_END   = 4'd1,
    EV_ATTR_CHAR  = 4'd2,
    EV_ATTR_END   = 4'd3,
    EV_VAL_CHAR   = 4'd4,
    EV_VAL_END    = 4'd5,
    EV_TEXT_CHAR  = 4'd6,
    EV_TEXT_END   = 4'd7,
    EV_CLOSE_CHAR = 4'd8,
    EV_LEAVE      = 4'd9,
    EV_SELF_LEAVE = 4'd10,
    EV_ERROR      = 4'd11
  } event_t;

  typedef struct packed {
    logic              valid;
    event_t            code;
    logic [BYTE_W-1:0] data;
  } lex_result_t;

  function automatic logic is_letter(input logic [BYTE_W-1:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_name_char(input logic [BYTE_W-1:0] c);
    return is_letter(c) || (c inside {[8'h30:8'h39], CH_UNDER, CH_DASH});
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF});
  endfunction

endpackage

// ===== design/xbt_in_if.sv =====
// Input channel of the tokenizer: one text byte per word.
// Depends on xbt_pkg.
interface xbt_in_if import xbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
  modport mon    (input valid, input ready, input in_byte);
endinterface

// ===== design/xbt_out_if.sv =====
// Output channel of the tokenizer: one tagged event per word.
// Depends on xbt_pkg.
interface xbt_out_if import xbt_pkg::*; ();
  logic              valid;
  logic              ready;
  event_t            event_code;
  logic [BYTE_W-1:0] out_byte;

  modport source (output valid, output event_code, output out_byte, input ready);
  modport sink   (input valid, input event_code, input out_byte, output ready);
  modport mon    (input valid, input ready, input event_code, input out_byte);
endinterface

// ===== design/xml_byte_tokenizer.sv =====
// Top level of the XML byte tokenizer: input register, lexer, event register.
// Depends on xbt_pkg, xbt_in_if, xbt_out_if and xbt_lexer.
//
// Usage:
//   text   - sink channel, one XML text byte (in_byte) per word.
//   events - source channel, one tagged event (event_code, out_byte) per
//            word; out_byte holds the character for char events, else zero.
//   A byte yields zero or one event. Bytes that give no event (comments,
//   top-level text, ignored bytes) simply vanish.
//   Path: a byte taken sits in the input register, is decoded by the lexer
//   once the event register is free and lands in the event register, from
//   which its event is offered.
//   Throughput: one byte per cycle while events are taken, set by the lexer
//   state update; the event register lets a new byte be taken while an event waits.
//   Stall: while an event is held unread the input register fills and ready
//   drops; it rises again in the cycle the event is taken.
//   Reset (rst, synchronous): lexer returns to the top-level state, both
//   registers empty. After a parse error one error event is sent and every
//   later byte is swallowed until reset.
module xml_byte_tokenizer import xbt_pkg::*; (
  input logic      clk,
  input logic      rst,
  xbt_in_if.sink   text,
  xbt_out_if.source events
);

  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              out_valid;
  event_t            out_code;
  logic [BYTE_W-1:0] out_data;
  logic              out_free;
  logic              step;
  lex_result_t       res;

  assign out_free   = !out_valid || events.ready;
  assign step       = stage_valid && out_free;
  assign text.ready = !stage_valid || out_free;

  xbt_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (stage_byte),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text.ready) begin
      stage_valid <= text.valid;
    end
    if (text.valid && text.ready) begin
      stage_byte <= text.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.valid;
    end
    if (step && res.valid) begin
      out_code <= res.code;
      out_data <= res.data;
    end
  end

  assign events.valid      = out_valid;
  assign events.event_code = out_code;
  assign events.out_byte   = out_data;

endmodule

// ===== design/xbt_lexer.sv =====
// Lexer state machine: holds the lexer state, the saved state and the quote
// kind, and decodes one byte per step into at most one event.
// Depends on xbt_pkg.
module xbt_lexer import xbt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] ch,
  output lex_result_t       res
);

  typedef enum logic [4:0] {
    ST_TOP        = 5'd0,
    ST_LT         = 5'd1,
    ST_CMT1       = 5'd2,
    ST_CMT2       = 5'd3,
    ST_CMT_BODY   = 5'd4,
    ST_CMT_END1   = 5'd5,
    ST_CMT_END2   = 5'd6,
    ST_ELEM_NAME  = 5'd7,
    ST_IN_TAG     = 5'd8,
    ST_ATTR_NAME  = 5'd9,
    ST_AFTER_ATTR = 5'd10,
    ST_BEFORE_VAL = 5'd11,
    ST_IN_VAL     = 5'd12,
    ST_CLOSE_NAME = 5'd13,
    ST_TEXT       = 5'd14,
    ST_SELF_CLOSE = 5'd15,
    ST_ERROR      = 5'd16
  } state_t;

  state_t state, state_next;
  state_t saved, saved_next;
  logic   quote_dbl, quote_dbl_next;

  state_t target;
  logic   go;
  logic   ev_valid;
  event_t ev_code;
  logic   carries;

  always_comb begin
    go             = 1'b0;
    target         = state;
    ev_valid       = 1'b0;
    ev_code        = EV_ERROR;
    carries        = 1'b0;
    quote_dbl_next = quote_dbl;
    state_next     = state;
    saved_next     = saved;

    case (state)
      ST_LT: begin
        if (ch == CH_BANG) begin
          go = 1'b1; target = ST_CMT1;
        end else if (is_letter(ch)) begin
          go = 1'b1; target = ST_ELEM_NAME;
          ev_valid = 1'b1; ev_code = EV_ELEM_CHAR; carries = 1'b1;
        end else if (ch == CH_SLASH) begin
          go = 1'b1; target = ST_CLOSE_NAME;
        end
      end
      ST_CMT1, ST_CMT2: begin
        go = 1'b1;
        if (ch == CH_DASH) begin
          target = (state == ST_CMT1) ? ST_CMT2 : ST_CMT_BODY;
        end else begin
          target = ST_ERROR;
          ev_valid = 1'b1; ev_code = EV_ERROR;
        end
      end
      ST_CMT_BODY: begin
        if (ch == CH_DASH) begin
          go = 1'b1; target = ST_CMT_END1;
        end
      end
      ST_CMT_END1: begin
        go = 1'b1;
        target = (ch == CH_DASH) ? ST_CMT_END2 : ST_CMT_BODY;
      end
      ST_CMT_END2: begin
        go = 1'b1;
        target = (ch == CH_GT) ? ST_TOP : ST_CMT_BODY;
      end
      ST_ELEM_NAME: begin
        if (is_name_char(ch)) begin
          ev_valid = 1'b1; ev_code = EV_ELEM_CHAR; carries = 1'b1;
        end else if (is_space(ch)) begin
          go = 1'b1; target = ST_IN_TAG;
          ev_valid = 1'b1; ev_code = EV_ELEM_END;
        end else if (ch == CH_GT) begin
          go = 1'b1; target = ST_TEXT;
          ev_valid = 1'b1; ev_code = EV_ELEM_END;
        end else if (ch == CH_SLASH) begin
          go = 1'b1; target = ST_SELF_CLOSE;
          ev_valid = 1'b1; ev_code = EV_ELEM_END;
        end
      end
      ST_IN_TAG: begin
        if (is_letter(ch)) begin
          go = 1'b1; target = ST_ATTR_NAME;
          ev_valid = 1'b1; ev_code = EV_ATTR_CHAR; carries = 1'b1;
        end else if (ch == CH_GT) begin
          go = 1'b1; target = ST_TEXT;
        end else if (ch == CH_SLASH) begin
          go = 1'b1; target = ST_SELF_CLOSE;
        end
      end
      ST_ATTR_NAME: begin
        if (is_name_char(ch)) begin
          ev_valid = 1'b1; ev_code = EV_ATTR_CHAR; carries = 1'b1;
        end else if (is_space(ch)) begin
          go = 1'b1; target = ST_AFTER_ATTR;
          ev_valid = 1'b1; ev_code = EV_ATTR_END;
        end else if (ch == CH_EQ) begin
          go = 1'b1; target = ST_BEFORE_VAL;
          ev_valid = 1'b1; ev_code = EV_ATTR_END;
        end
      end
      ST_AFTER_ATTR: begin
        if (ch == CH_EQ) begin
          go = 1'b1; target = ST_BEFORE_VAL;
        end
      end
      ST_BEFORE_VAL: begin
        if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
          quote_dbl_next = (ch == CH_DQUOTE);
          go = 1'b1; target = ST_IN_VAL;
        end
      end
      ST_IN_VAL: begin
        if (ch == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
          go = 1'b1; target = ST_IN_TAG;
          ev_valid = 1'b1; ev_code = EV_VAL_END;
        end else begin
          ev_valid = 1'b1; ev_code = EV_VAL_CHAR; carries = 1'b1;
        end
      end
      ST_CLOSE_NAME: begin
        if (is_name_char(ch)) begin
          ev_valid = 1'b1; ev_code = EV_CLOSE_CHAR; carries = 1'b1;
        end else if (ch == CH_GT) begin
          go = 1'b1; target = ST_TOP;
          ev_valid = 1'b1; ev_code = EV_LEAVE;
        end
      end
      ST_TEXT: begin
        if (ch == CH_LT) begin
          go = 1'b1; target = ST_LT;
          ev_valid = 1'b1; ev_code = EV_TEXT_END;
        end else begin
          ev_valid = 1'b1; ev_code = EV_TEXT_CHAR; carries = 1'b1;
        end
      end
      ST_SELF_CLOSE: begin
        if (ch == CH_GT) begin
          go = 1'b1; target = ST_TOP;
          ev_valid = 1'b1; ev_code = EV_SELF_LEAVE;
        end else begin
          // broken self-close: fall back, saved state left as it is
          state_next = saved;
        end
      end
      ST_ERROR: begin
      end
      default: begin
        // top level and any unused code
        if (ch == CH_LT) begin
          go = 1'b1; target = ST_LT;
        end
      end
    endcase

    if (go) begin
      saved_next = state;
      state_next = target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_TOP;
      saved     <= ST_TOP;
      quote_dbl <= 1'b0;
    end else if (step) begin
      state     <= state_next;
      saved     <= saved_next;
      quote_dbl <= quote_dbl_next;
    end
  end

  assign res.valid = ev_valid;
  assign res.code  = ev_code;
  assign res.data  = carries ? ch : '0;

endmodule

// ===== design/xbt_checker.sv =====
// Port-level checks for the XML byte tokenizer, bound to the top level.
// Depends on xbt_pkg.
module xbt_checker import xbt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              text_valid,
  input logic              text_ready,
  input logic              events_valid,
  input logic              events_ready,
  input event_t            event_code,
  input logic [BYTE_W-1:0] out_byte
);

  // held event must not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    events_valid && !events_ready |=>
      events_valid && $stable(event_code) && $stable(out_byte))
    else $error("event changed while stalled");

  // events without a character carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    events_valid && (event_code == EV_ELEM_END ||
      event_code == EV_ATTR_END || event_code == EV_VAL_END ||
      event_code == EV_TEXT_END || event_code == EV_LEAVE ||
      event_code == EV_SELF_LEAVE || event_code == EV_ERROR)
      |-> out_byte == '0)
    else $error("non-char event with nonzero byte");

  // error is sticky and silent: nothing follows it
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    events_valid && events_ready && event_code == EV_ERROR |=> !events_valid)
    else $error("event after parse error");

  // with no event held the input side is always open
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !events_valid |-> text_ready)
    else $error("input stalled with no event held");

  a_reset: assert property (@(posedge clk) rst |=> !events_valid)
    else $error("event offered after reset");

  // the byte word itself is not checked here
  logic unused_text_valid;
  assign unused_text_valid = text_valid;

endmodule

bind xml_byte_tokenizer xbt_checker u_xbt_checker (
  .clk          (clk),
  .rst          (rst),
  .text_valid   (text.valid),
  .text_ready   (text.ready),
  .events_valid (events.valid),
  .events_ready (events.ready),
  .event_code   (events.event_code),
  .out_byte     (events.out_byte)
);

// ===== tb/tb_xml_byte_tokenizer.sv =====
// Self-checking bench for xml_byte_tokenizer: a lexer predictor in a small
// scoreboard follows every byte word taken and checks every event word.
// Depends on xbt_pkg, xbt_in_if, xbt_out_if and the tokenizer RTL.
module tb_xml_byte_tokenizer;
  import xbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int CHUNKS       = 10;
  localparam int CHUNK_BYTES  = 130;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [4:0] {
    S_TOP    = 5'd0,
    S_LT     = 5'd1,
    S_CMT1   = 5'd2,
    S_CMT2   = 5'd3,
    S_CBODY  = 5'd4,
    S_CEND1  = 5'd5,
    S_CEND2  = 5'd6,
    S_ELEM   = 5'd7,
    S_TAG    = 5'd8,
    S_ATTR   = 5'd9,
    S_AFTER  = 5'd10,
    S_BEFORE = 5'd11,
    S_VAL    = 5'd12,
    S_CLOSE  = 5'd13,
    S_TEXT   = 5'd14,
    S_SELF   = 5'd15,
    S_ERROR  = 5'd16
  } lex_st_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  xbt_in_if  text_ch();
  xbt_out_if event_ch();

  xml_byte_tokenizer DUT (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .events (event_ch)
  );

  always #10 clk = ~clk;

  function automatic bit chr_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit chr_name(input logic [7:0] c);
    return chr_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DASH;
  endfunction

  function automatic bit chr_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // One lexer step: next state, held state, quote kind and the event, if any.
  function automatic void lex_advance(
    input  lex_st_t     st,
    input  lex_st_t     sv,
    input  bit          dq,
    input  logic [7:0]  c,
    output lex_st_t     nst,
    output lex_st_t     nsv,
    output bit          ndq,
    output bit          hit,
    output event_t      code,
    output logic [7:0]  data
  );
    bit keep;
    nst  = st;
    nsv  = sv;
    ndq  = dq;
    hit  = 1'b0;
    code = EV_ERROR;
    keep = 1'b0;
    case (st)
      S_LT: begin
        if (c == CH_BANG) begin
          nsv = st; nst = S_CMT1;
        end else if (chr_alpha(c)) begin
          nsv = st; nst = S_ELEM; hit = 1'b1; code = EV_ELEM_CHAR; keep = 1'b1;
        end else if (c == CH_SLASH) begin
          nsv = st; nst = S_CLOSE;
        end
      end
      S_CMT1, S_CMT2: begin
        nsv = st;
        if (c == CH_DASH) begin
          nst = (st == S_CMT1) ? S_CMT2 : S_CBODY;
        end else begin
          nst = S_ERROR; hit = 1'b1; code = EV_ERROR;
        end
      end
      S_CBODY: begin
        if (c == CH_DASH) begin
          nsv = st; nst = S_CEND1;
        end
      end
      S_CEND1: begin
        nsv = st;
        nst = (c == CH_DASH) ? S_CEND2 : S_CBODY;
      end
      S_CEND2: begin
        nsv = st;
        nst = (c == CH_GT) ? S_TOP : S_CBODY;
      end
      S_ELEM: begin
        if (chr_name(c)) begin
          hit = 1'b1; code = EV_ELEM_CHAR; keep = 1'b1;
        end else if (chr_blank(c)) begin
          nsv = st; nst = S_TAG; hit = 1'b1; code = EV_ELEM_END;
        end else if (c == CH_GT) begin
          nsv = st; nst = S_TEXT; hit = 1'b1; code = EV_ELEM_END;
        end else if (c == CH_SLASH) begin
          nsv = st; nst = S_SELF; hit = 1'b1; code = EV_ELEM_END;
        end
      end
      S_TAG: begin
        if (chr_alpha(c)) begin
          nsv = st; nst = S_ATTR; hit = 1'b1; code = EV_ATTR_CHAR; keep = 1'b1;
        end else if (c == CH_GT) begin
          nsv = st; nst = S_TEXT;
        end else if (c == CH_SLASH) begin
          nsv = st; nst = S_SELF;
        end
      end
      S_ATTR: begin
        if (chr_name(c)) begin
          hit = 1'b1; code = EV_ATTR_CHAR; keep = 1'b1;
        end else if (chr_blank(c)) begin
          nsv = st; nst = S_AFTER; hit = 1'b1; code = EV_ATTR_END;
        end else if (c == CH_EQ) begin
          nsv = st; nst = S_BEFORE; hit = 1'b1; code = EV_ATTR_END;
        end
      end
      S_AFTER: begin
        if (c == CH_EQ) begin
          nsv = st; nst = S_BEFORE;
        end
      end
      S_BEFORE: begin
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          ndq = (c == CH_DQUOTE);
          nsv = st; nst = S_VAL;
        end
      end
      S_VAL: begin
        if (c == (dq ? CH_DQUOTE : CH_SQUOTE)) begin
          nsv = st; nst = S_TAG; hit = 1'b1; code = EV_VAL_END;
        end else begin
          hit = 1'b1; code = EV_VAL_CHAR; keep = 1'b1;
        end
      end
      S_CLOSE: begin
        if (chr_name(c)) begin
          hit = 1'b1; code = EV_CLOSE_CHAR; keep = 1'b1;
        end else if (c == CH_GT) begin
          nsv = st; nst = S_TOP; hit = 1'b1; code = EV_LEAVE;
        end
      end
      S_TEXT: begin
        if (c == CH_LT) begin
          nsv = st; nst = S_LT; hit = 1'b1; code = EV_TEXT_END;
        end else begin
          hit = 1'b1; code = EV_TEXT_CHAR; keep = 1'b1;
        end
      end
      S_SELF: begin
        // broken self-close falls back to whatever came before the '/'
        if (c == CH_GT) begin
          nsv = st; nst = S_TOP; hit = 1'b1; code = EV_SELF_LEAVE;
        end else begin
          nst = sv;
        end
      end
      S_ERROR: ;
      default: begin
        if (c == CH_LT) begin
          nsv = st; nst = S_LT;
        end
      end
    endcase
    data = keep ? c : 8'h00;
  endfunction

  class event_scoreboard;
    lex_st_t    st;
    lex_st_t    sv;
    bit         dq;
    event_t     pend_code[$];
    logic [7:0] pend_byte[$];
    int         mismatches;

    function new();
      st = S_TOP;
      sv = S_TOP;
      dq = 1'b0;
      mismatches = 0;
    endfunction

    function void note_byte(input logic [7:0] c);
      lex_st_t    nst;
      lex_st_t    nsv;
      bit         ndq;
      bit         hit;
      event_t     code;
      logic [7:0] data;
      lex_advance(st, sv, dq, c, nst, nsv, ndq, hit, code, data);
      st = nst;
      sv = nsv;
      dq = ndq;
      if (hit) begin
        pend_code.push_back(code);
        pend_byte.push_back(data);
      end
    endfunction

    function void check_event(input event_t code, input logic [7:0] data);
      event_t     want_code;
      logic [7:0] want_byte;
      if (pend_code.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected event word: code %0d byte %02h", code, data);
        return;
      end
      want_code = pend_code.pop_front();
      want_byte = pend_byte.pop_front();
      if (code !== want_code || data !== want_byte) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("event mismatch: expected code %0d byte %02h, got code %0d byte %02h",
                   want_code, want_byte, code, data);
      end
    endfunction

    function int pending();
      return pend_code.size();
    endfunction
  endclass

  event_scoreboard sb;

  // bytes waiting to be offered, with a shadow lexer used only to steer them
  logic [7:0] tx_bytes[$];
  lex_st_t    g_st;
  lex_st_t    g_sv;
  bit         g_dq;

  int burst_left;
  int idle_cycles;
  int hold_req;
  int hold_done;
  int rx_mode;
  int rx_left;
  int rx_tick;

  // Keep the run clear of the sticky error until the very end: inside "<!"
  // or "<!-" anything but '-' is swapped for '-' when guard is set.
  function automatic void push_byte(input logic [7:0] c, input bit guard);
    lex_st_t    nst;
    lex_st_t    nsv;
    bit         ndq;
    bit         hit;
    event_t     code;
    logic [7:0] data;
    if (guard && (g_st == S_CMT1 || g_st == S_CMT2) && c != CH_DASH)
      c = CH_DASH;
    lex_advance(g_st, g_sv, g_dq, c, nst, nsv, ndq, hit, code, data);
    g_st = nst;
    g_sv = nsv;
    g_dq = ndq;
    tx_bytes.push_back(c);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], 1'b1);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0)
      return 8'h41 + 8'($urandom_range(0, 25));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_name_char();
    case ($urandom_range(0, 5))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return CH_UNDER;
      2:       return CH_DASH;
      default: return rand_letter();
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return CH_TAB;
      1:       return CH_CR;
      2:       return CH_LF;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic void push_name();
    int n;
    n = $urandom_range(1, 6);
    push_byte(rand_letter(), 1'b1);
    for (int i = 1; i < n; i++)
      push_byte(rand_name_char(), 1'b1);
  endfunction

  function automatic void push_elem_text();
    int         n;
    logic [7:0] c;
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(8'h20, 8'h7E));
      if (c == CH_LT)
        c = 8'h61;
      push_byte(c, 1'b1);
    end
  endfunction

  function automatic void push_open_tag();
    int         nattr;
    int         nval;
    logic [7:0] q;
    logic [7:0] c;
    push_byte(CH_LT, 1'b1);
    push_name();
    nattr = $urandom_range(0, 3);
    for (int a = 0; a < nattr; a++) begin
      push_byte(rand_blank(), 1'b1);
      if ($urandom_range(0, 4) == 0)
        push_byte(rand_blank(), 1'b1);
      if ($urandom_range(0, 7) == 0)
        push_byte(8'($urandom_range(0, 255)), 1'b1);  // stray byte in the tag
      push_name();
      if ($urandom_range(0, 3) == 0)
        push_byte(rand_blank(), 1'b1);
      push_byte(CH_EQ, 1'b1);
      if ($urandom_range(0, 4) == 0)
        push_byte(rand_blank(), 1'b1);
      q = ($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_SQUOTE;
      push_byte(q, 1'b1);
      nval = $urandom_range(0, 8);
      for (int i = 0; i < nval; i++) begin
        c = 8'($urandom_range(0, 255));
        if (c == q)
          c = 8'h7A;
        push_byte(c, 1'b1);
      end
      push_byte(q, 1'b1);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        push_byte(CH_GT, 1'b1);
        push_elem_text();
      end
      6, 7: begin
        push_byte(CH_SLASH, 1'b1);
        push_byte(CH_GT, 1'b1);
      end
      default: begin
        // broken self-close, then name characters or a proper end
        push_byte(CH_SLASH, 1'b1);
        push_byte(($urandom_range(0, 1) == 0) ? rand_name_char()
                                               : 8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 1) == 0)
          push_byte(rand_name_char(), 1'b1);
        push_byte(CH_GT, 1'b1);
        push_elem_text();
      end
    endcase
  endfunction

  function automatic void push_close_tag();
    push_byte(CH_LT, 1'b1);
    push_byte(CH_SLASH, 1'b1);
    push_name();
    if ($urandom_range(0, 5) == 0)
      push_byte(8'($urandom_range(0, 255)), 1'b1);
    push_byte(CH_GT, 1'b1);
  endfunction

  function automatic void push_comment();
    int n;
    push_text("<!--");
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0:       push_byte(CH_DASH, 1'b1);
        1:       push_text("--x");
        default: push_byte(8'($urandom_range(0, 255)), 1'b1);
      endcase
    end
    push_text("-->");
  endfunction

  function automatic void fill_chunk();
    while (tx_bytes.size() < CHUNK_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_open_tag();
        4, 5:       push_close_tag();
        6:          push_comment();
        7:          push_elem_text();
        default: begin
          for (int i = $urandom_range(1, 3); i > 0; i--)
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end
      endcase
    end
  endfunction

  // Steers the shadow lexer towards a bad comment start from wherever it is.
  function automatic logic [7:0] byte_towards_error();
    case (g_st)
      S_LT:                    return CH_BANG;
      S_CMT1, S_CMT2:          return 8'h78;
      S_CBODY, S_CEND1:        return CH_DASH;
      S_CEND2:                 return CH_GT;
      S_ELEM, S_TAG, S_CLOSE,
      S_SELF:                  return CH_GT;
      S_ATTR, S_AFTER:         return CH_EQ;
      S_BEFORE:                return CH_DQUOTE;
      S_VAL:                   return g_dq ? CH_DQUOTE : CH_SQUOTE;
      default:                 return CH_LT;
    endcase
  endfunction

  task automatic send_queued();
    logic [7:0] b;
    int         gap;
    while (tx_bytes.size() > 0) begin
      b = tx_bytes.pop_front();
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          text_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      text_ch.valid   <= 1'b1;
      text_ch.in_byte <= b;
      @(posedge clk);
      while (!text_ch.ready) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // receiver: changing stall patterns, plus one long hold on request
  initial begin
    event_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        event_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_req;
        event_ch.ready <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
          0:       event_ch.ready <= 1'b1;
          1:       event_ch.ready <= 1'($urandom_range(0, 1));
          2:       event_ch.ready <= ($urandom_range(0, 7) != 0);
          default: event_ch.ready <= (rx_tick % 4 != 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (event_ch.valid && event_ch.ready)
        sb.check_event(event_ch.event_code, event_ch.out_byte);
      if (text_ch.valid && text_ch.ready)
        sb.note_byte(text_ch.in_byte);
    end
  end

  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (event_ch.valid && event_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sb = new();
    text_ch.valid   = 1'b0;
    text_ch.in_byte = 8'h00;
    g_st = S_TOP;
    g_sv = S_TOP;
    g_dq = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // top-level text, name/attribute/value extremes, stray byte in a tag,
    // broken self-close, empty element text, close tag and self-close
    push_text("x<Z9 #b =\"");
    push_byte(8'hFF, 1'b1);
    push_byte(CH_SQUOTE, 1'b1);
    push_byte(8'h00, 1'b1);
    push_text("\"/q></z><y/>");
    send_queued();
    wait_drained();

    // long receiver hold while the sender keeps offering element text
    hold_req++;
    push_text("<p>");
    for (int i = 0; i < 30; i++)
      push_byte(($urandom_range(0, 1) == 0) ? 8'h41 : 8'($urandom_range(8'h3D, 8'hFF)),
                1'b1);
    push_text("</p>");
    send_queued();
    wait_drained();

    for (int k = 0; k < CHUNKS; k++) begin
      fill_chunk();
      send_queued();
      if ($urandom_range(0, 2) == 0)
        wait_drained();
    end

    // bad comment start, then bytes that must all be swallowed
    while (g_st != S_ERROR)
      push_byte(byte_towards_error(), 1'b0);
    for (int i = 0; i < 30; i++)
      push_byte(8'($urandom_range(0, 255)), 1'b0);
    send_queued();
    wait_drained();
    repeat (5) @(posedge clk);

    if (sb.pending() != 0)
      sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
